@@ rtl/core/tlps_pkg.sv @@
// tlps_pkg: shared types, constants and codes for the two-level job scheduler
// used by tlps_if, tlps_queues and two_level_priority_job_scheduler
// no dependencies
package tlps_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;

  // queue level index, system queue is the high one
  localparam int LVL_LOW  = 0;
  localparam int LVL_HIGH = 1;

  // input operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 3'd0,
    KIND_DROP   = 3'd1,
    KIND_IDLE   = 3'd2,
    KIND_RUN    = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  // one queued job, arrival stamp on top
  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // push request from the control into the queues
  typedef struct packed {
    logic   valid;
    logic   level;
    entry_t entry;
  } push_req_t;

  // pop request from the control into the queues
  typedef struct packed {
    logic valid;
    logic level;
  } pop_req_t;

  // queue status back to the control, indexed by level
  typedef struct packed {
    logic [1:0] nonempty;
    logic [1:0] full;
  } q_status_t;

  // one result word
  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    run_id;
    logic               run_level;
    logic [TIME_W-1:0]  tick_start;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
  } result_t;

endpackage

@@ rtl/core/tlps_if.sv @@
// tlps_if: valid/ready channel interfaces for input and result words
// depends on tlps_pkg
interface tlps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [tlps_pkg::ID_W-1:0]    job_id;
  logic [tlps_pkg::BURST_W-1:0] burst_len;
  logic                        is_system;

  modport source (output valid, op, job_id, burst_len, is_system, input ready);
  modport sink   (input valid, op, job_id, burst_len, is_system, output ready);
endinterface

interface tlps_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlps_pkg::KIND_W-1:0]  kind;
  logic [tlps_pkg::ID_W-1:0]    run_id;
  logic                        run_level;
  logic [tlps_pkg::TIME_W-1:0]  tick_start;
  logic [tlps_pkg::TIME_W-1:0]  turnaround;
  logic [tlps_pkg::TIME_W-1:0]  waiting;

  modport source (output valid, kind, run_id, run_level, tick_start, turnaround, waiting,
                  input ready);
  modport sink   (input valid, kind, run_id, run_level, tick_start, turnaround, waiting,
                  output ready);
endinterface

@@ rtl/core/two_level_priority_job_scheduler.sv @@
// two_level_priority_job_scheduler: control, running job and time counter
// depends on tlps_pkg, tlps_if and tlps_queues
// Results: an arrival, an idle tick or a tick of a running job gives its result word
//   in the register in the cycle after acceptance; a tick that starts a queued job
//   first passes through S_POP, where the queue memory read of the head entry lands.
// Throughput: one word per cycle while the result side is ready; no word is taken in S_POP.
// Reset (synchronous): queues empty, no job running, time zero; memories not cleared.
module two_level_priority_job_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  tlps_in_if.sink           in_ch,
  tlps_out_if.source        out_ch
);

  localparam int TIME_W  = tlps_pkg::TIME_W;
  localparam int ID_W    = tlps_pkg::ID_W;
  localparam int BURST_W = tlps_pkg::BURST_W;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               running_r, running_nxt;
  logic [ID_W-1:0]    run_id_r, run_id_nxt;
  logic               run_level_r, run_level_nxt;
  logic [BURST_W-1:0] run_burst_r, run_burst_nxt;
  logic [TIME_W-1:0]  run_arr_r, run_arr_nxt;
  logic [BURST_W-1:0] remaining_r, remaining_nxt;
  logic               out_valid_r, out_valid_nxt;
  tlps_pkg::result_t  out_data_r, out_data_nxt;

  tlps_pkg::push_req_t push;
  tlps_pkg::pop_req_t  pop;
  tlps_pkg::q_status_t qstat;
  tlps_pkg::entry_t    rd_entry;

  logic               out_free;
  logic               accept;
  logic               any_waiting;

  // run path operands
  logic [ID_W-1:0]    x_id;
  logic               x_level;
  logic [BURST_W-1:0] x_burst;
  logic [TIME_W-1:0]  x_arr;
  logic [BURST_W-1:0] x_rem;
  logic [BURST_W-1:0] rem_dec;
  logic [TIME_W-1:0]  now_inc;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  wait_t;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign any_waiting = qstat.nonempty[tlps_pkg::LVL_HIGH] || qstat.nonempty[tlps_pkg::LVL_LOW];

  // queue requests
  always_comb begin
    push.valid       = accept && (in_ch.op == tlps_pkg::OP_ARRIVE) &&
                       (in_ch.burst_len != '0) && !qstat.full[in_ch.is_system];
    push.level       = in_ch.is_system;
    push.entry.arrival = now_r;
    push.entry.burst = in_ch.burst_len;
    push.entry.id    = in_ch.job_id;
    pop.valid        = accept && (in_ch.op == tlps_pkg::OP_TICK) && !running_r && any_waiting;
    pop.level        = qstat.nonempty[tlps_pkg::LVL_HIGH];
  end

  tlps_queues u_queues (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .status   (qstat),
    .rd_entry (rd_entry)
  );

  // one service tick, on the freshly popped entry or on the running job
  always_comb begin
    if (state_r == S_POP) begin
      x_id    = rd_entry.id;
      x_level = run_level_r;
      x_burst = rd_entry.burst;
      x_arr   = rd_entry.arrival;
      x_rem   = rd_entry.burst;
    end else begin
      x_id    = run_id_r;
      x_level = run_level_r;
      x_burst = run_burst_r;
      x_arr   = run_arr_r;
      x_rem   = remaining_r;
    end
    rem_dec = x_rem - 1'b1;
    now_inc = now_r + 1'b1;
    tat     = now_inc - x_arr;
    wait_t  = tat - TIME_W'(x_burst);
  end

  // next state and result word
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    running_nxt   = running_r;
    run_id_nxt    = run_id_r;
    run_level_nxt = run_level_r;
    run_burst_nxt = run_burst_r;
    run_arr_nxt   = run_arr_r;
    remaining_nxt = remaining_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt.tick_start = now_r;
          out_data_nxt.turnaround = '0;
          out_data_nxt.waiting    = '0;
          if (in_ch.op == tlps_pkg::OP_ARRIVE) begin
            // arrival: queued or dropped, no time passes
            out_valid_nxt          = 1'b1;
            out_data_nxt.kind      = push.valid ? tlps_pkg::KIND_ACCEPT : tlps_pkg::KIND_DROP;
            out_data_nxt.run_id    = in_ch.job_id;
            out_data_nxt.run_level = in_ch.is_system;
          end else if (running_r) begin
            // tick of the running job
            out_valid_nxt          = 1'b1;
            now_nxt                = now_inc;
            remaining_nxt          = rem_dec;
            out_data_nxt.run_id    = x_id;
            out_data_nxt.run_level = x_level;
            if (rem_dec == '0) begin
              running_nxt             = 1'b0;
              out_data_nxt.kind       = tlps_pkg::KIND_DONE;
              out_data_nxt.turnaround = tat;
              out_data_nxt.waiting    = wait_t;
            end else begin
              out_data_nxt.kind = tlps_pkg::KIND_RUN;
            end
          end else if (any_waiting) begin
            // start a job: wait for the head entry
            state_nxt     = S_POP;
            run_level_nxt = pop.level;
          end else begin
            // nothing to run
            out_valid_nxt          = 1'b1;
            now_nxt                = now_inc;
            out_data_nxt.kind      = tlps_pkg::KIND_IDLE;
            out_data_nxt.run_id    = '0;
            out_data_nxt.run_level = 1'b0;
          end
        end
      end
      S_POP: begin
        // first tick of the popped job, time has not moved since the tick was taken
        state_nxt               = S_IDLE;
        out_valid_nxt           = 1'b1;
        now_nxt                 = now_inc;
        run_id_nxt              = x_id;
        run_burst_nxt           = x_burst;
        run_arr_nxt             = x_arr;
        remaining_nxt           = rem_dec;
        out_data_nxt.tick_start = now_r;
        out_data_nxt.turnaround = '0;
        out_data_nxt.waiting    = '0;
        out_data_nxt.run_id     = x_id;
        out_data_nxt.run_level  = x_level;
        if (rem_dec == '0) begin
          running_nxt             = 1'b0;
          out_data_nxt.kind       = tlps_pkg::KIND_DONE;
          out_data_nxt.turnaround = tat;
          out_data_nxt.waiting    = wait_t;
        end else begin
          running_nxt       = 1'b1;
          out_data_nxt.kind = tlps_pkg::KIND_RUN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      running_r   <= 1'b0;
      run_id_r    <= '0;
      run_level_r <= 1'b0;
      run_burst_r <= '0;
      run_arr_r   <= '0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      running_r   <= running_nxt;
      run_id_r    <= run_id_nxt;
      run_level_r <= run_level_nxt;
      run_burst_r <= run_burst_nxt;
      run_arr_r   <= run_arr_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_data_r.kind;
  assign out_ch.run_id     = out_data_r.run_id;
  assign out_ch.run_level  = out_data_r.run_level;
  assign out_ch.tick_start = out_data_r.tick_start;
  assign out_ch.turnaround = out_data_r.turnaround;
  assign out_ch.waiting    = out_data_r.waiting;

  // a job is only fetched while none is running
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !running_r)
    else $error("queue fetch while a job is running");
  // the fetch cycle always delivers a result word
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("fetch did not produce a result");
  // a running job never sits at zero remaining ticks
  a_running_rem: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (remaining_r != '0))
    else $error("running job with no ticks left");
  // a tick with empty queues and no job reports idle
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.op == tlps_pkg::OP_TICK) && !running_r && !any_waiting)
    |=> (out_valid_r && (out_data_r.kind == tlps_pkg::KIND_IDLE)))
    else $error("idle tick not reported");

endmodule

@@ rtl/core/tlps_ram.sv @@
// tlps_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module tlps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tlps_queues.sv @@
// tlps_queues: system and user circular queues, ram storage plus head/count
// depends on tlps_pkg and tlps_ram
module tlps_queues (
  input  logic                clk,
  input  logic                rst_n,
  input  tlps_pkg::push_req_t push,
  input  tlps_pkg::pop_req_t  pop,
  output tlps_pkg::q_status_t status,
  output tlps_pkg::entry_t    rd_entry
);

  localparam int IDX_W = tlps_pkg::IDX_W;
  localparam int CNT_W = tlps_pkg::CNT_W;
  localparam int DEPTH = tlps_pkg::QUEUE_DEPTH;

  logic [IDX_W-1:0]           head_r  [2];
  logic [CNT_W-1:0]           count_r [2];
  logic [tlps_pkg::ENTRY_W-1:0] rdata [2];
  logic                       pop_level_r;

  for (genvar g = 0; g < 2; g++) begin : g_lvl
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head_nxt;
    logic [CNT_W-1:0] count_nxt;
    logic             do_push;
    logic             do_pop;

    assign do_push = push.valid && (push.level == g[0]);
    assign do_pop  = pop.valid && (pop.level == g[0]);

    // write slot is head plus count, wrapped once
    always_comb begin
      tail_sum = {1'b0, head_r[g]} + (IDX_W + 1)'(count_r[g]);
      if (tail_sum >= (IDX_W + 1)'(DEPTH)) begin
        tail_sum = tail_sum - (IDX_W + 1)'(DEPTH);
      end
      tail = tail_sum[IDX_W-1:0];
    end

    // head and fill level
    always_comb begin
      head_nxt  = head_r[g];
      count_nxt = count_r[g];
      if (do_pop) begin
        head_nxt = (head_r[g] == IDX_W'(DEPTH - 1)) ? '0 : head_r[g] + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_nxt = count_r[g] + 1'b1;
      end else if (do_pop && !do_push) begin
        count_nxt = count_r[g] - 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r[g]  <= '0;
        count_r[g] <= '0;
      end else begin
        head_r[g]  <= head_nxt;
        count_r[g] <= count_nxt;
      end
    end

    // storage, read address follows the head so a pop sees its entry next cycle
    tlps_ram #(
      .DEPTH (DEPTH),
      .WIDTH (tlps_pkg::ENTRY_W)
    ) u_ram (
      .clk   (clk),
      .we    (do_push),
      .waddr (tail),
      .wdata (push.entry),
      .raddr (head_r[g]),
      .rdata (rdata[g])
    );

    assign status.nonempty[g] = (count_r[g] != '0);
    assign status.full[g]     = (count_r[g] == CNT_W'(DEPTH));
  end

  // remember which queue was popped to steer the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_level_r <= 1'b0;
    end else if (pop.valid) begin
      pop_level_r <= pop.level;
    end
  end

  assign rd_entry = tlps_pkg::entry_t'(rdata[pop_level_r]);

  // fill levels stay within the depth
  a_high_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[tlps_pkg::LVL_HIGH] <= CNT_W'(DEPTH))
    else $error("system queue count over depth");
  a_low_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[tlps_pkg::LVL_LOW] <= CNT_W'(DEPTH))
    else $error("user queue count over depth");
  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop.valid |-> status.nonempty[pop.level])
    else $error("pop from empty queue");
  // never push a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !status.full[push.level])
    else $error("push into full queue");

endmodule

@@ bench/tb_two_level_priority_job_scheduler.sv @@
// tb_two_level_priority_job_scheduler: self-checking bench for the two-level job scheduler
// drives arrivals and ticks, predicts every result word and compares it field by field
// depends on tlps_pkg, tlps_if and the scheduler rtl
`timescale 1ns / 1ps

module tb_two_level_priority_job_scheduler;
  import tlps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTS = 50;

  // one row of the directed part, with the result typed in where it is obvious
  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic               sys;
    logic               known;
    result_t            want;
  } intro_row_t;

  localparam int INTRO_LEN = 20;
  localparam intro_row_t INTRO_ROWS [INTRO_LEN] = '{
    // idle tick out of reset, then zero-burst drops on both levels
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b1, '{KIND_IDLE,   8'h00, 1'b0, 32'd0, 32'd0, 32'd0}},
    '{OP_ARRIVE, 8'hff, 16'd0,     1'b1, 1'b1, '{KIND_DROP,   8'hff, 1'b1, 32'd1, 32'd0, 32'd0}},
    '{OP_ARRIVE, 8'h00, 16'd0,     1'b0, 1'b1, '{KIND_DROP,   8'h00, 1'b0, 32'd1, 32'd0, 32'd0}},
    // user job queued first, system job still wins
    '{OP_ARRIVE, 8'ha5, 16'd1,     1'b0, 1'b1, '{KIND_ACCEPT, 8'ha5, 1'b0, 32'd1, 32'd0, 32'd0}},
    '{OP_ARRIVE, 8'h5a, 16'd2,     1'b1, 1'b1, '{KIND_ACCEPT, 8'h5a, 1'b1, 32'd1, 32'd0, 32'd0}},
    '{OP_TICK,   8'hff, 16'hffff,  1'b0, 1'b1, '{KIND_RUN,    8'h5a, 1'b1, 32'd1, 32'd0, 32'd0}},
    '{OP_ARRIVE, 8'h3c, 16'd3,     1'b1, 1'b1, '{KIND_ACCEPT, 8'h3c, 1'b1, 32'd2, 32'd0, 32'd0}},
    '{OP_TICK,   8'h00, 16'd0,     1'b1, 1'b1, '{KIND_DONE,   8'h5a, 1'b1, 32'd2, 32'd2, 32'd0}},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    // one-tick user job starts and finishes on the same tick
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    // system job arriving while a user job runs does not preempt it
    '{OP_ARRIVE, 8'h11, 16'd3,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_ARRIVE, 8'h22, 16'd1,     1'b1, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0},
    '{OP_TICK,   8'h00, 16'd0,     1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  tlps_in_if  in_bus ();
  tlps_out_if out_bus ();

  two_level_priority_job_scheduler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler shadow state
  entry_t             sys_jobs[$];
  entry_t             user_jobs[$];
  logic               job_running = 1'b0;
  entry_t             cur_job = '0;
  logic               cur_level = 1'b0;
  logic [BURST_W-1:0] ticks_left = '0;
  logic [TIME_W-1:0]  clock_now = '0;

  result_t pending_results[$];
  logic    word_known = 1'b0;
  result_t word_typed = '0;
  logic    idle_on = 1'b0;
  int      stall_left = 0;
  int      cycle_count = 0;
  int      error_count = 0;
  int      items_sent = 0;

  // advance the shadow scheduler by one word and return the result it causes
  function automatic result_t schedule_step(input logic op, input logic [ID_W-1:0] id,
                                            input logic [BURST_W-1:0] burst, input logic sys);
    result_t           r;
    entry_t            e;
    logic [TIME_W-1:0] tat;
    r = '0;
    r.tick_start = clock_now;
    if (op == OP_ARRIVE) begin
      r.run_id = id;
      r.run_level = sys;
      if (burst == '0 || (sys ? sys_jobs.size() : user_jobs.size()) >= QUEUE_DEPTH) begin
        r.kind = KIND_DROP;
      end else begin
        e.arrival = clock_now;
        e.burst = burst;
        e.id = id;
        if (sys) sys_jobs.push_back(e);
        else user_jobs.push_back(e);
        r.kind = KIND_ACCEPT;
      end
      return r;
    end
    // pick a new job when nothing runs, system level first
    if (!job_running) begin
      if (sys_jobs.size() != 0) begin
        cur_job = sys_jobs.pop_front();
        cur_level = 1'b1;
      end else if (user_jobs.size() != 0) begin
        cur_job = user_jobs.pop_front();
        cur_level = 1'b0;
      end else begin
        r.kind = KIND_IDLE;
        clock_now = clock_now + 1'b1;
        return r;
      end
      job_running = 1'b1;
      ticks_left = cur_job.burst;
    end
    r.run_id = cur_job.id;
    r.run_level = cur_level;
    ticks_left = ticks_left - 1'b1;
    clock_now = clock_now + 1'b1;
    if (ticks_left == '0) begin
      tat = clock_now - cur_job.arrival;
      r.kind = KIND_DONE;
      r.turnaround = tat;
      r.waiting = tat - TIME_W'(cur_job.burst);
      job_running = 1'b0;
    end else begin
      r.kind = KIND_RUN;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string field, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  // drive one word from a falling edge and return at the falling edge after acceptance
  task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                           input logic [BURST_W-1:0] burst, input logic sys,
                           input logic known, input result_t typed);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.op <= op;
    in_bus.job_id <= id;
    in_bus.burst_len <= burst;
    in_bus.is_system <= sys;
    word_known <= known;
    word_typed <= typed;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // tick until both queues are empty and no job runs
  task automatic drain_queues();
    while (job_running || sys_jobs.size() != 0 || user_jobs.size() != 0)
      send_word(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
  endtask

  // result side stalls in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // check result words, then predict for the accepted input word
  always @(posedge clk) begin
    result_t want;
    result_t predicted;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("kind", TIME_W'(out_bus.kind), TIME_W'(want.kind));
          check_field("run_id", TIME_W'(out_bus.run_id), TIME_W'(want.run_id));
          check_field("run_level", TIME_W'(out_bus.run_level), TIME_W'(want.run_level));
          check_field("tick_start", out_bus.tick_start, want.tick_start);
          check_field("turnaround", out_bus.turnaround, want.turnaround);
          check_field("waiting", out_bus.waiting, want.waiting);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        predicted = schedule_step(in_bus.op, in_bus.job_id, in_bus.burst_len, in_bus.is_system);
        pending_results.push_back(word_known ? word_typed : predicted);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    int                 seg_len;
    int                 arrive_pct;
    int                 pick;
    int                 fill;
    logic               lvl;
    logic               paused_once;
    logic [BURST_W-1:0] b;
    paused_once = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_ARRIVE;
    in_bus.job_id = '0;
    in_bus.burst_len = '0;
    in_bus.is_system = 1'b0;
    out_bus.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    idle_on = 1'b1;
    for (int i = 0; i < INTRO_LEN; i++)
      send_word(INTRO_ROWS[i].op, INTRO_ROWS[i].id, INTRO_ROWS[i].burst, INTRO_ROWS[i].sys,
                INTRO_ROWS[i].known, INTRO_ROWS[i].want);

    // random segments: mixed traffic, and now and then a flood past a full queue
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (!paused_once && items_sent > RANDOM_ITEMS / 2) begin
        in_bus.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        lvl = 1'($urandom_range(0, 1));
        fill = QUEUE_DEPTH - (lvl ? sys_jobs.size() : user_jobs.size()) + $urandom_range(1, 4);
        repeat (fill) begin
          b = ((lvl ? sys_jobs.size() : user_jobs.size()) >= QUEUE_DEPTH) ?
              16'($urandom) : 16'($urandom_range(1, 2));
          send_word(OP_ARRIVE, 8'($urandom), b, lvl, 1'b0, '0);
        end
        drain_queues();
      end else begin
        seg_len = $urandom_range(20, 60);
        arrive_pct = $urandom_range(10, 35);
        repeat (seg_len) begin
          if ($urandom_range(0, 99) < arrive_pct) begin
            pick = $urandom_range(0, 19);
            b = (pick == 0) ? 16'd0 :
                (pick < 16) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(5, 24));
            send_word(OP_ARRIVE, 8'($urandom), b, 1'($urandom), 1'b0, '0);
          end else begin
            send_word(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
          end
        end
      end
    end

    // last part without idling: drain, then long jobs that stay queued
    idle_on = 1'b0;
    drain_queues();
    for (int i = 0; i < 6; i++)
      send_word(OP_ARRIVE, 8'($urandom), (i == 0) ? 16'hffff : 16'($urandom_range(1, 65535)),
                1'(i), 1'b0, '0);
    in_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tlps_pkg.sv
rtl/core/tlps_if.sv
rtl/core/tlps_ram.sv
rtl/core/tlps_queues.sv
rtl/core/two_level_priority_job_scheduler.sv
bench/tb_two_level_priority_job_scheduler.sv
